// ----- rtl/bsp_pkg.sv -----
// Shared types and constants for the battery and solar power monitor.
`default_nettype none

package bsp_pkg;

  // field widths
  localparam int unsigned RAW_W   = 10;
  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned THR_W   = 10;

  // APB configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_DEPLOY_BELOW  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RETRACT_ABOVE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTRUSION_THR = 2'd2;

  localparam logic [LEVEL_W-1:0] DEPLOY_BELOW_RST  = 7'd20;
  localparam logic [LEVEL_W-1:0] RETRACT_ABOVE_RST = 7'd95;
  localparam logic [THR_W-1:0]   INTRUSION_THR_RST = 10'd300;

  // floor(raw*98/1000) == (raw * 102761) >> 20 for every 10-bit raw
  localparam int unsigned          LEVEL_MULT_W = 17;
  localparam logic [LEVEL_MULT_W-1:0] LEVEL_MULT = 17'd102761;
  localparam int unsigned          LEVEL_SHIFT  = 20;
  localparam int unsigned          LEVEL_PROD_W = RAW_W + LEVEL_MULT_W;

  // temperature = raw*32 + 33
  localparam int unsigned        TEMP_SHIFT  = 5;
  localparam logic [TEMP_W-1:0]  TEMP_OFFSET = 16'd33;

  // over-temperature test 5*t > 6*m, sized to hold 6 * 65535
  localparam int unsigned        HOT_W     = TEMP_W + 3;
  localparam logic [HOT_W-1:0]   HOT_T_MUL = 19'd5;
  localparam logic [HOT_W-1:0]   HOT_M_MUL = 19'd6;

  typedef struct packed {
    logic [LEVEL_W-1:0] deploy_below;
    logic [LEVEL_W-1:0] retract_above;
    logic [THR_W-1:0]   intrusion_thr;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/bsp_ifs.sv -----
// Valid/ready channel interfaces for the monitor's sample and result beats.
`default_nettype none

interface bsp_in_if;
  import bsp_pkg::*;

  logic               valid;
  logic               ready;
  logic [RAW_W-1:0]   level_raw;
  logic [RAW_W-1:0]   temp_raw_a;
  logic [RAW_W-1:0]   temp_raw_b;
  logic [RAW_W-1:0]   intrusion_raw;
  logic               panel_done;

  modport source (
    output valid, level_raw, temp_raw_a, temp_raw_b, intrusion_raw, panel_done,
    input  ready
  );
  modport sink (
    input  valid, level_raw, temp_raw_a, temp_raw_b, intrusion_raw, panel_done,
    output ready
  );
endinterface

interface bsp_out_if;
  import bsp_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] battery_percent;
  logic [TEMP_W-1:0]  temp_a;
  logic [TEMP_W-1:0]  temp_b;
  logic               panel_deployed;
  logic               deploy_cmd;
  logic               retract_cmd;
  logic               motor_stop;
  logic               intrusion_alert;
  logic               overtemp_alarm;

  modport source (
    output valid, battery_percent, temp_a, temp_b, panel_deployed, deploy_cmd,
           retract_cmd, motor_stop, intrusion_alert, overtemp_alarm,
    input  ready
  );
  modport sink (
    input  valid, battery_percent, temp_a, temp_b, panel_deployed, deploy_cmd,
           retract_cmd, motor_stop, intrusion_alert, overtemp_alarm,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/bsp_cfg_regs.sv -----
// APB register file holding the monitor's thresholds.
`default_nettype none

module bsp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bsp_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [bsp_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [bsp_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output bsp_pkg::cfg_t                       cfg
);
  import bsp_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DEPLOY_BELOW:  cfg_nxt.deploy_below  = pwdata[LEVEL_W-1:0];
        REG_RETRACT_ABOVE: cfg_nxt.retract_above = pwdata[LEVEL_W-1:0];
        REG_INTRUSION_THR: cfg_nxt.intrusion_thr = pwdata[THR_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEPLOY_BELOW:  prdata = APB_DATA_W'(cfg_r.deploy_below);
      REG_RETRACT_ABOVE: prdata = APB_DATA_W'(cfg_r.retract_above);
      REG_INTRUSION_THR: prdata = APB_DATA_W'(cfg_r.intrusion_thr);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deploy_below  <= DEPLOY_BELOW_RST;
      cfg_r.retract_above <= RETRACT_ABOVE_RST;
      cfg_r.intrusion_thr <= INTRUSION_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/battery_solar_power_monitor.sv -----
// Battery and solar panel power monitor: top level.
//
// One input beat on in_ch is one sample period: battery level ADC, two
// temperature ADCs, the intrusion ADC and a panel-motion-done flag. Each
// sample yields exactly one result beat on out_ch with the scaled battery
// percent, converted temperatures, panel state, held deploy/retract
// commands, motor stop, intrusion alert and the sticky over-temperature alarm.
// Thresholds sit in three APB registers at 0x0, 0x4 and 0x8; write them only
// while no sample is in flight.
// The accepting edge loads the input register; the result register then
// takes the computed beat once it is empty or being drained, raising
// out_ch.valid. Throughput: one sample per cycle while out_ch does not
// stall, set by the combinational compute between the two registers.
// If out_ch stalls, the result register holds its beat and the input
// register still takes one more sample; in_ch.ready drops only when both are
// full. Reset (rst_n low, synchronous) empties both stages, retracts the
// panel, clears the commands, stored level, temperature history and alarm,
// and loads the threshold defaults 20, 95 and 300.
`default_nettype none

module battery_solar_power_monitor (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bsp_in_if.sink                              in_ch,
  bsp_out_if.source                           out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [bsp_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [bsp_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic      [bsp_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);
  import bsp_pkg::*;

  cfg_t cfg;

  bsp_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input stage
  logic             s1_v_r;
  logic [RAW_W-1:0] s1_level_raw_r;
  logic [RAW_W-1:0] s1_temp_raw_a_r;
  logic [RAW_W-1:0] s1_temp_raw_b_r;
  logic [RAW_W-1:0] s1_intr_raw_r;
  logic             s1_done_r;

  // sample state
  logic               dep_r;
  logic               deploy_r;
  logic               retract_r;
  logic [LEVEL_W-1:0] last_level_r;
  logic [TEMP_W-1:0]  ta0_r, ta1_r, tb0_r, tb1_r;
  logic               ot_r;

  // result stage
  logic               out_v_r;
  logic [LEVEL_W-1:0] o_level_r;
  logic [TEMP_W-1:0]  o_ta_r, o_tb_r;
  logic               o_dep_r, o_deploy_r, o_retract_r, o_stop_r, o_alert_r, o_ot_r;

  logic in_fire, adv;

  assign adv          = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // compute
  logic                    dep_nxt, deploy_nxt, retract_nxt, ot_nxt, alert;
  logic [LEVEL_PROD_W-1:0] level_prod;
  logic [LEVEL_W-1:0]      level;
  logic [TEMP_W-1:0]       ta, tb, max_a, max_b;
  logic                    hot_a, hot_b;

  assign dep_nxt = dep_r ^ s1_done_r;

  always_comb begin
    deploy_nxt  = deploy_r;
    retract_nxt = retract_r;
    // hysteresis uses the level stored by the previous sample
    if (!dep_nxt && last_level_r <= cfg.deploy_below) begin
      deploy_nxt  = 1'b1;
      retract_nxt = 1'b0;
    end
    if (dep_nxt && last_level_r > cfg.retract_above) begin
      deploy_nxt  = 1'b0;
      retract_nxt = 1'b1;
    end
  end

  assign level_prod = LEVEL_PROD_W'(s1_level_raw_r) * LEVEL_PROD_W'(LEVEL_MULT);
  assign level      = level_prod[LEVEL_SHIFT +: LEVEL_W];

  assign ta = TEMP_W'({s1_temp_raw_a_r, {TEMP_SHIFT{1'b0}}}) + TEMP_OFFSET;
  assign tb = TEMP_W'({s1_temp_raw_b_r, {TEMP_SHIFT{1'b0}}}) + TEMP_OFFSET;

  assign max_a = (ta0_r > ta1_r) ? ta0_r : ta1_r;
  assign max_b = (tb0_r > tb1_r) ? tb0_r : tb1_r;
  assign hot_a = (HOT_W'(ta) * HOT_T_MUL) > (HOT_W'(max_a) * HOT_M_MUL);
  assign hot_b = (HOT_W'(tb) * HOT_T_MUL) > (HOT_W'(max_b) * HOT_M_MUL);
  assign ot_nxt = ot_r || hot_a || hot_b;

  assign alert = s1_intr_raw_r > cfg.intrusion_thr;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      dep_r        <= 1'b0;
      deploy_r     <= 1'b0;
      retract_r    <= 1'b0;
      last_level_r <= '0;
      ta0_r        <= '0;
      ta1_r        <= '0;
      tb0_r        <= '0;
      tb1_r        <= '0;
      ot_r         <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (adv) begin
        dep_r        <= dep_nxt;
        deploy_r     <= deploy_nxt;
        retract_r    <= retract_nxt;
        last_level_r <= level;
        ta1_r        <= ta0_r;
        ta0_r        <= ta;
        tb1_r        <= tb0_r;
        tb0_r        <= tb;
        ot_r         <= ot_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level_raw_r  <= in_ch.level_raw;
      s1_temp_raw_a_r <= in_ch.temp_raw_a;
      s1_temp_raw_b_r <= in_ch.temp_raw_b;
      s1_intr_raw_r   <= in_ch.intrusion_raw;
      s1_done_r       <= in_ch.panel_done;
    end
    if (adv) begin
      o_level_r   <= level;
      o_ta_r      <= ta;
      o_tb_r      <= tb;
      o_dep_r     <= dep_nxt;
      o_deploy_r  <= deploy_nxt;
      o_retract_r <= retract_nxt;
      o_stop_r    <= s1_done_r;
      o_alert_r   <= alert;
      o_ot_r      <= ot_nxt;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.battery_percent = o_level_r;
  assign out_ch.temp_a          = o_ta_r;
  assign out_ch.temp_b          = o_tb_r;
  assign out_ch.panel_deployed  = o_dep_r;
  assign out_ch.deploy_cmd      = o_deploy_r;
  assign out_ch.retract_cmd     = o_retract_r;
  assign out_ch.motor_stop      = o_stop_r;
  assign out_ch.intrusion_alert = o_alert_r;
  assign out_ch.overtemp_alarm  = o_ot_r;

endmodule

`default_nettype wire

// ----- rtl/bsp_checker.sv -----
// Port-level assertions for the power monitor, bound to the top level.
`default_nettype none

module bsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  battery_percent,
  input wire logic [15:0] temp_a,
  input wire logic        panel_deployed,
  input wire logic        deploy_cmd,
  input wire logic        retract_cmd,
  input wire logic        motor_stop,
  input wire logic        overtemp_alarm
);

  logic out_beat;
  logic seen_alarm_r;
  logic last_dep_r;

  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_alarm_r <= 1'b0;
      last_dep_r   <= 1'b0;
    end else if (out_beat) begin
      seen_alarm_r <= seen_alarm_r || overtemp_alarm;
      last_dep_r   <= panel_deployed;
    end
  end

  // a stalled result beat must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(battery_percent)
      && $stable(temp_a) && $stable(overtemp_alarm))
    else $error("result beat changed while stalled");

  // alarm stays up until reset
  a_alarm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_alarm_r |-> overtemp_alarm)
    else $error("over-temperature alarm dropped");

  // panel state only moves when motor stop is reported
  a_panel_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> panel_deployed == (last_dep_r ^ motor_stop))
    else $error("panel state inconsistent with motor stop");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(deploy_cmd && retract_cmd))
    else $error("deploy and retract both asserted");

  // percent is capped at 100, temp_a has the form raw*32+33
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> battery_percent <= 7'd100 && temp_a[4:0] == 5'd1)
    else $error("result field out of range");

endmodule

bind battery_solar_power_monitor bsp_checker u_bsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .battery_percent (out_ch.battery_percent),
  .temp_a          (out_ch.temp_a),
  .panel_deployed  (out_ch.panel_deployed),
  .deploy_cmd      (out_ch.deploy_cmd),
  .retract_cmd     (out_ch.retract_cmd),
  .motor_stop      (out_ch.motor_stop),
  .overtemp_alarm  (out_ch.overtemp_alarm)
);

`default_nettype wire
